/* rtl/linear_congruence_combiner_core_defines.svh */
// assertion macros shared by the rtl modules
`ifndef LINEAR_CONGRUENCE_COMBINER_CORE_DEFINES_SVH
`define LINEAR_CONGRUENCE_COMBINER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LCC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lcc assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define LCC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lcc assertion failed");

`endif

/* rtl/lcc_pkg.sv */
// types and constants of the linear congruence combiner
package lcc_pkg;

	localparam int IN_W   = 32;
	localparam int ACC_W  = 63;
	localparam int OPA_W  = 64;
	localparam int PROD_W = OPA_W + IN_W;
	localparam int CNT_W  = 7;

	localparam logic [CNT_W-1:0] LONG_STEPS  = CNT_W'(OPA_W);
	localparam logic [CNT_W-1:0] SHORT_STEPS = CNT_W'(IN_W);

	localparam logic [ACC_W-1:0] MOD_MAX = {ACC_W{1'b1}};

	typedef enum logic {
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
		logic    shrt;
	} alu_req_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_MM,
		S_RM,
		S_AM,
		S_BM,
		S_SM,
		S_S,
		S_ARM,
		S_AR,
		S_GCD,
		S_TD,
		S_MP,
		S_SD,
		S_SDM,
		S_EUC,
		S_EMUL,
		S_EMOD,
		S_UMUL,
		S_U,
		S_PM,
		S_RU,
		S_EMIT
	} state_t;

endpackage

/* rtl/lcc_alu.sv */
// shared shift-add multiplier and restoring divider
`include "linear_congruence_combiner_core_defines.svh"

module lcc_alu (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lcc_pkg::alu_req_t              req,
	input  logic [lcc_pkg::OPA_W-1:0]      opa,
	input  logic [lcc_pkg::IN_W-1:0]       opb,
	output logic                           done,
	output logic [lcc_pkg::OPA_W-1:0]      quot,
	output logic [lcc_pkg::IN_W-1:0]       rem,
	output logic [lcc_pkg::PROD_W-1:0]     prod
);

	logic                            busy_q;
	logic                            done_q;
	lcc_pkg::alu_op_t                op_q;
	logic [lcc_pkg::CNT_W-1:0]       cnt_q;
	logic [lcc_pkg::PROD_W:0]        wk_q;
	logic [lcc_pkg::OPA_W-1:0]       opnd_q;

	logic [lcc_pkg::IN_W:0]          rem_sh;
	logic [lcc_pkg::IN_W+1:0]        trial;
	logic [lcc_pkg::PROD_W:0]        div_nxt;
	logic [lcc_pkg::OPA_W:0]         sum;
	logic [lcc_pkg::PROD_W:0]        mul_nxt;

	// divide step: {rem, dividend} shifts left one bit per cycle
	always_comb begin
		rem_sh = wk_q[lcc_pkg::PROD_W-1 -: (lcc_pkg::IN_W+1)];
		trial  = {1'b0, rem_sh} - {2'b00, opnd_q[lcc_pkg::IN_W-1:0]};
		if (!trial[lcc_pkg::IN_W+1]) begin
			div_nxt = {trial[lcc_pkg::IN_W:0], wk_q[lcc_pkg::OPA_W-2:0], 1'b1};
		end else begin
			div_nxt = {rem_sh, wk_q[lcc_pkg::OPA_W-2:0], 1'b0};
		end
	end

	// multiply step: add multiplicand on multiplier lsb, shift right
	always_comb begin
		sum = wk_q[lcc_pkg::PROD_W:lcc_pkg::IN_W]
			+ (wk_q[0] ? {1'b0, opnd_q} : {(lcc_pkg::OPA_W+1){1'b0}});
		mul_nxt = {1'b0, sum, wk_q[lcc_pkg::IN_W-1:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= (req.op == lcc_pkg::ALU_DIV && !req.shrt) ?
					lcc_pkg::LONG_STEPS : lcc_pkg::SHORT_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == lcc_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			op_q <= req.op;
			unique case (req.op)
				lcc_pkg::ALU_MUL: begin
					opnd_q <= opa;
					wk_q   <= {{(lcc_pkg::OPA_W+1){1'b0}}, opb};
				end
				lcc_pkg::ALU_DIV: begin
					opnd_q <= {{(lcc_pkg::OPA_W-lcc_pkg::IN_W){1'b0}}, opb};
					if (req.shrt) begin
						wk_q <= {{(lcc_pkg::IN_W+1){1'b0}}, opa[lcc_pkg::IN_W-1:0],
							{lcc_pkg::IN_W{1'b0}}};
					end else begin
						wk_q <= {{(lcc_pkg::IN_W+1){1'b0}}, opa};
					end
				end
				default: wk_q <= wk_q;
			endcase
		end else if (busy_q) begin
			wk_q <= (op_q == lcc_pkg::ALU_DIV) ? div_nxt : mul_nxt;
		end
	end

	assign done = done_q;
	assign quot = wk_q[lcc_pkg::OPA_W-1:0];
	assign rem  = wk_q[lcc_pkg::OPA_W +: lcc_pkg::IN_W];
	assign prod = wk_q[lcc_pkg::PROD_W-1:0];

	`LCC_ASSERT_IMP(a_no_start_busy, busy_q, !(req.start && done_q))
	`LCC_ASSERT_NXT(a_done_ends_busy, busy_q && cnt_q == lcc_pkg::CNT_W'(1), done && !busy_q)
	`LCC_ASSERT_IMP(a_done_one_cycle, done_q, !busy_q)

endmodule

/* rtl/linear_congruence_combiner_core.sv */
// linear congruence combiner: sequencer, running state and result register
// Folds congruences coef*x = rhs (mod modulus) into a running solution
// residue (mod combined_mod), starting at (0, 1).
// Input channel in_valid/in_ready carries coef, rhs, modulus, last; a zero
// modulus counts as one. Output channel out_valid/out_ready carries one item
// per accepted congruence, except for an inconsistent congruence and the
// later ones of that system, which give nothing until the one marked last.
// Multiplies and divides run on one shared shift-add multiplier / restoring
// divider; a long divide takes more steps than a short divide or a multiply.
// An item runs a gcd loop and an extended-Euclid loop, with up to about 46
// steps in each loop. An inconsistent item ends after its gcd steps and the
// trial divide; an item after a failure or overflow goes straight to the
// emit state. in_ready is high only while the sequencer is idle.
// A result waits in the output register while the next item is taken; if
// the receiver still stalls when that item is done, the sequencer holds.
// Reset clears the running state to (0, 1) with both flags low; the state
// returns there after each item marked last.
`include "linear_congruence_combiner_core_defines.svh"

module linear_congruence_combiner_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lcc_pkg::IN_W-1:0]      coef,
	input  logic [lcc_pkg::IN_W-1:0]      rhs,
	input  logic [lcc_pkg::IN_W-1:0]      modulus,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lcc_pkg::ACC_W-1:0]     residue,
	output logic [lcc_pkg::ACC_W-1:0]     combined_mod,
	output logic                          no_solution,
	output logic                          overflowed,
	output logic                          final_res
);

	localparam int W = lcc_pkg::IN_W;

	lcc_pkg::state_t state_q, state_nxt;
	logic            issued_q;

	lcc_pkg::alu_req_t            req;
	logic [lcc_pkg::OPA_W-1:0]    opa;
	logic [W-1:0]                 opb;
	logic                         alu_done;
	logic [lcc_pkg::OPA_W-1:0]    quot;
	logic [W-1:0]                 rem;
	logic [lcc_pkg::PROD_W-1:0]   prod;

	logic [lcc_pkg::ACC_W-1:0] acc_res_q, acc_mod_q;
	logic                      fail_q, ovf_q;
	logic [W-1:0] a_q, b_q, m_q;
	logic         last_q;
	logic [W-1:0] mm_q, rm_q, am_q, bm_q, s_q, t_q, p_q, q_q;
	logic [W-1:0] td_q, mp_q, r0_q, r1_q, c0_q, c1_q, qd_q;
	logic [lcc_pkg::OPA_W-1:0] x_q;

	logic                      out_valid_q;
	logic [lcc_pkg::ACC_W-1:0] res_q, cmod_q;
	logic                      nosol_q, ovfo_q, fin_q;

	logic [W:0]   tsum;
	logic         prod_ovf;
	logic         emit_go;
	logic         skip;

	lcc_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.opa    (opa),
		.opb    (opb),
		.done   (alu_done),
		.quot   (quot),
		.rem    (rem),
		.prod   (prod)
	);

	assign tsum     = {1'b0, bm_q} + {1'b0, m_q} - {1'b0, rem};
	assign prod_ovf = |prod[lcc_pkg::PROD_W-1:lcc_pkg::ACC_W];
	assign emit_go  = (fail_q && !last_q) || !out_valid_q || out_ready;
	// loop exits that need no arithmetic
	assign skip     = (state_q == lcc_pkg::S_GCD && q_q == '0)
		|| (state_q == lcc_pkg::S_EUC && r1_q == '0);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			lcc_pkg::S_IDLE:
				if (in_valid) state_nxt = (fail_q || ovf_q) ? lcc_pkg::S_EMIT : lcc_pkg::S_MM;
			lcc_pkg::S_MM:   if (alu_done) state_nxt = lcc_pkg::S_RM;
			lcc_pkg::S_RM:   if (alu_done) state_nxt = lcc_pkg::S_AM;
			lcc_pkg::S_AM:   if (alu_done) state_nxt = lcc_pkg::S_BM;
			lcc_pkg::S_BM:   if (alu_done) state_nxt = lcc_pkg::S_SM;
			lcc_pkg::S_SM:   if (alu_done) state_nxt = lcc_pkg::S_S;
			lcc_pkg::S_S:    if (alu_done) state_nxt = lcc_pkg::S_ARM;
			lcc_pkg::S_ARM:  if (alu_done) state_nxt = lcc_pkg::S_AR;
			lcc_pkg::S_AR:   if (alu_done) state_nxt = lcc_pkg::S_GCD;
			lcc_pkg::S_GCD:  if (q_q == '0) state_nxt = lcc_pkg::S_TD;
			lcc_pkg::S_TD:
				if (alu_done) state_nxt = (rem != '0) ? lcc_pkg::S_EMIT : lcc_pkg::S_MP;
			lcc_pkg::S_MP:   if (alu_done) state_nxt = lcc_pkg::S_SD;
			lcc_pkg::S_SD:   if (alu_done) state_nxt = lcc_pkg::S_SDM;
			lcc_pkg::S_SDM:  if (alu_done) state_nxt = lcc_pkg::S_EUC;
			lcc_pkg::S_EUC:
				priority if (r1_q == '0) state_nxt = lcc_pkg::S_UMUL;
				else if (alu_done)       state_nxt = lcc_pkg::S_EMUL;
			lcc_pkg::S_EMUL: if (alu_done) state_nxt = lcc_pkg::S_EMOD;
			lcc_pkg::S_EMOD: if (alu_done) state_nxt = lcc_pkg::S_EUC;
			lcc_pkg::S_UMUL: if (alu_done) state_nxt = lcc_pkg::S_U;
			lcc_pkg::S_U:    if (alu_done) state_nxt = lcc_pkg::S_PM;
			lcc_pkg::S_PM:
				if (alu_done) state_nxt = prod_ovf ? lcc_pkg::S_EMIT : lcc_pkg::S_RU;
			lcc_pkg::S_RU:   if (alu_done) state_nxt = lcc_pkg::S_EMIT;
			lcc_pkg::S_EMIT: if (emit_go) state_nxt = lcc_pkg::S_IDLE;
			default:         state_nxt = lcc_pkg::S_IDLE;
		endcase
	end

	// unit request and operands
	always_comb begin
		req.start = 1'b0;
		req.op    = lcc_pkg::ALU_DIV;
		req.shrt  = 1'b1;
		opa       = '0;
		opb       = m_q;
		unique case (state_q)
			lcc_pkg::S_MM: begin
				opa = {1'b0, acc_mod_q}; req.shrt = 1'b0;
			end
			lcc_pkg::S_RM: begin
				opa = {1'b0, acc_res_q}; req.shrt = 1'b0;
			end
			lcc_pkg::S_AM: opa = {{W{1'b0}}, a_q};
			lcc_pkg::S_BM: opa = {{W{1'b0}}, b_q};
			lcc_pkg::S_SM: begin
				req.op = lcc_pkg::ALU_MUL; opa = {{W{1'b0}}, am_q}; opb = mm_q;
			end
			lcc_pkg::S_S: begin
				opa = x_q; req.shrt = 1'b0;
			end
			lcc_pkg::S_ARM: begin
				req.op = lcc_pkg::ALU_MUL; opa = {{W{1'b0}}, am_q}; opb = rm_q;
			end
			lcc_pkg::S_AR: begin
				opa = x_q; req.shrt = 1'b0;
			end
			lcc_pkg::S_GCD: begin
				opa = {{W{1'b0}}, p_q}; opb = q_q;
			end
			lcc_pkg::S_TD: begin
				opa = {{W{1'b0}}, t_q}; opb = p_q;
			end
			lcc_pkg::S_MP: begin
				opa = {{W{1'b0}}, m_q}; opb = p_q;
			end
			lcc_pkg::S_SD: begin
				opa = {{W{1'b0}}, s_q}; opb = p_q;
			end
			lcc_pkg::S_SDM: begin
				opa = {{W{1'b0}}, x_q[W-1:0]}; opb = mp_q;
			end
			lcc_pkg::S_EUC: begin
				opa = {{W{1'b0}}, r0_q}; opb = r1_q;
			end
			lcc_pkg::S_EMUL: begin
				req.op = lcc_pkg::ALU_MUL; opa = {{W{1'b0}}, qd_q}; opb = c1_q;
			end
			lcc_pkg::S_EMOD, lcc_pkg::S_U: begin
				opa = x_q; opb = mp_q; req.shrt = 1'b0;
			end
			lcc_pkg::S_UMUL: begin
				req.op = lcc_pkg::ALU_MUL; opa = {{W{1'b0}}, td_q}; opb = c0_q;
			end
			lcc_pkg::S_PM: begin
				req.op = lcc_pkg::ALU_MUL; opa = {1'b0, acc_mod_q}; opb = mp_q;
			end
			lcc_pkg::S_RU: begin
				req.op = lcc_pkg::ALU_MUL; opa = {1'b0, acc_mod_q}; opb = qd_q;
			end
			default: opa = '0;
		endcase
		req.start = (state_q != lcc_pkg::S_IDLE) && (state_q != lcc_pkg::S_EMIT)
			&& !issued_q && !skip;
	end

	assign in_ready = (state_q == lcc_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lcc_pkg::S_IDLE;
			issued_q    <= 1'b0;
			acc_res_q   <= '0;
			acc_mod_q   <= lcc_pkg::ACC_W'(1);
			fail_q      <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (alu_done) begin
				issued_q <= 1'b0;
			end else if (req.start) begin
				issued_q <= 1'b1;
			end
			if (state_q == lcc_pkg::S_EMIT && emit_go && (!fail_q || last_q)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				lcc_pkg::S_TD:
					if (alu_done && rem != '0) fail_q <= 1'b1;
				lcc_pkg::S_PM:
					if (alu_done && prod_ovf) begin
						ovf_q     <= 1'b1;
						acc_mod_q <= lcc_pkg::MOD_MAX;
						acc_res_q <= '0;
					end
				lcc_pkg::S_RU:
					if (alu_done) begin
						acc_res_q <= acc_res_q + prod[lcc_pkg::ACC_W-1:0];
						acc_mod_q <= x_q[lcc_pkg::ACC_W-1:0];
					end
				lcc_pkg::S_EMIT:
					if (emit_go && last_q) begin
						acc_res_q <= '0;
						acc_mod_q <= lcc_pkg::ACC_W'(1);
						fail_q    <= 1'b0;
						ovf_q     <= 1'b0;
					end
				default: fail_q <= fail_q;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (state_q == lcc_pkg::S_IDLE && in_valid) begin
			a_q    <= coef;
			b_q    <= rhs;
			m_q    <= (modulus == '0) ? W'(1) : modulus;
			last_q <= last;
		end
		if (state_q == lcc_pkg::S_EMIT && emit_go && (!fail_q || last_q)) begin
			res_q   <= fail_q ? '0 : acc_res_q;
			cmod_q  <= fail_q ? lcc_pkg::ACC_W'(1) : acc_mod_q;
			nosol_q <= fail_q;
			ovfo_q  <= ovf_q;
			fin_q   <= last_q;
		end
		if (alu_done) begin
			unique case (state_q)
				lcc_pkg::S_MM:  mm_q <= rem;
				lcc_pkg::S_RM:  rm_q <= rem;
				lcc_pkg::S_AM:  am_q <= rem;
				lcc_pkg::S_BM:  bm_q <= rem;
				lcc_pkg::S_SM, lcc_pkg::S_ARM, lcc_pkg::S_EMUL, lcc_pkg::S_UMUL:
					x_q <= prod[lcc_pkg::OPA_W-1:0];
				lcc_pkg::S_S: begin
					s_q <= rem;
					p_q <= m_q;
					q_q <= rem;
				end
				// t = (b - a*r) mod m, operands already below m
				lcc_pkg::S_AR:
					t_q <= (tsum >= {1'b0, m_q}) ? W'(tsum - {1'b0, m_q}) : tsum[W-1:0];
				lcc_pkg::S_GCD: begin
					p_q <= q_q;
					q_q <= rem;
				end
				lcc_pkg::S_TD:  td_q <= quot[W-1:0];
				lcc_pkg::S_MP:  mp_q <= quot[W-1:0];
				lcc_pkg::S_SD:  x_q  <= quot;
				lcc_pkg::S_SDM: begin
					r0_q <= rem;
					r1_q <= mp_q;
					c0_q <= (mp_q == W'(1)) ? '0 : W'(1);
					c1_q <= '0;
				end
				lcc_pkg::S_EUC: begin
					qd_q <= quot[W-1:0];
					r0_q <= r1_q;
					r1_q <= rem;
				end
				// coefficients kept reduced mod m'
				lcc_pkg::S_EMOD: begin
					c0_q <= c1_q;
					c1_q <= (c0_q >= rem) ? c0_q - rem : c0_q + mp_q - rem;
				end
				lcc_pkg::S_U:   qd_q <= rem;
				lcc_pkg::S_PM:  x_q  <= prod[lcc_pkg::OPA_W-1:0];
				default:        mm_q <= mm_q;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign residue      = res_q;
	assign combined_mod = cmod_q;
	assign no_solution  = nosol_q;
	assign overflowed   = ovfo_q;
	assign final_res    = fin_q;

	`LCC_ASSERT_IMP(a_mod_nonzero, 1'b1, acc_mod_q != '0)
	`LCC_ASSERT_NXT(a_accept_busy, in_valid && in_ready, !in_ready)
	`LCC_ASSERT_IMP(a_done_issued, alu_done, issued_q)
	`LCC_ASSERT_IMP(a_fail_res_clear, out_valid && no_solution, residue == '0)

endmodule
